@@ rtl/plq_pkg.sv @@
// plq_pkg: sizes, codes and shared types of the polygon locate query block
// no dependencies; imported by every module of the block

package plq_pkg;

    localparam int MaxPolygons = 256;
    localparam int MaxVertices = 8;
    localparam int PolyW       = $clog2(MaxPolygons);
    localparam int VertW       = $clog2(MaxVertices);
    localparam int AddrW       = PolyW + VertW;
    localparam int CountW      = 4;
    localparam int PolyCountW  = 9;
    localparam int RadiusW     = 31;
    localparam int CoordW      = 32;
    localparam int MagW        = 32;
    localparam int MulW        = 33;
    localparam int ProdW       = 2 * MulW;
    localparam int SumW        = 66;
    localparam int NumW        = 2 * SumW;
    localparam int QuoW        = 68;
    localparam int DistW       = 64;
    localparam int R2W         = 2 * RadiusW;
    localparam int StepW       = 4;
    localparam int CfgIdxW     = 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CfgIdxW-1:0] CFG_POLYGON_COUNT = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_AGENT_RADIUS  = 1'd1;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
    } vertex_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_GET,
        ST_LD_A,
        ST_LD_B,
        ST_LD_C,
        ST_DIFF,
        ST_MUL,
        ST_ACC,
        ST_DECIDE,
        ST_DIV_GO,
        ST_DIV,
        ST_EDGE_END,
        ST_POLY_END,
        ST_FINAL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MODE_CONTAIN,
        MODE_DIST,
        MODE_WIDE,
        MODE_RADIUS
    } mode_t;

endpackage

@@ rtl/polygon_locate_query.sv @@
// polygon_locate_query: top level, sequencer and datapath of the polygon locator
// depends on plq_pkg, plq_vertex_store, plq_count_store, plq_mul_unit, plq_divider

// A query scans polygons in index order on one shared 33x33 multiplier and a
// one-bit-a-cycle divider. Per polygon the vertex count is read; for a polygon of 3
// or more vertices each edge gets a crossing test whose products run only when the
// edge crosses the point's z. If the point is not inside, each edge of the distance
// pass runs its products, and the 68-step divide runs only when the point projects
// inside the edge. A containing polygon ends the scan at once. The closing count
// check, the radius check and the output transfer end the query.
// in_ready is low for the whole query; writes are taken while a result still
// waits in the output register.

module polygon_locate_query
    import plq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CfgIdxW-1:0]       cfg_index,
    input  logic [RadiusW-1:0]       cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic [PolyW-1:0]         poly_slot,
    input  logic [VertW-1:0]         vertex_slot,
    input  logic [CountW-1:0]        vertex_total,
    input  logic signed [CoordW-1:0] coord_x,
    input  logic signed [CoordW-1:0] coord_y,
    input  logic signed [CoordW-1:0] coord_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     found,
    output logic [PolyW-1:0]         match_index,
    output logic                     contained
);

    state_t state_reg, state_next;
    mode_t  mode_reg;

    logic [PolyCountW-1:0] pcount_reg;
    logic [RadiusW-1:0]    radius_reg;
    logic [PolyCountW-1:0] n_reg;
    logic [PolyCountW-1:0] poly_reg;
    logic [VertW-1:0]      edge_reg;
    logic [CountW-1:0]     cnt_reg;
    logic [StepW-1:0]      step_reg;
    logic                  contain_phase_reg;
    logic                  inside_reg;
    logic                  out_valid_reg;

    logic signed [CoordW-1:0] ptx_reg, pty_reg, ptz_reg;
    vertex_t va_reg, vb_reg;
    logic [MagW:0] d_reg [3];
    logic [MagW:0] w_reg [3];
    logic [MagW:0] f_reg [3];
    logic [MagW:0] lx_reg, ex_reg, pz_reg, dz_reg;
    logic [SumW-1:0] ww_reg, ff_reg, ll_reg, pos_reg, neg_reg, dot_reg;
    logic signed [ProdW:0] s1_reg;
    logic [NumW-1:0]  wacc_reg;
    logic [DistW-1:0] dk_reg, dist_reg, best_reg;
    logic [PolyW-1:0] best_idx_reg;
    logic [R2W-1:0]   r2_reg;
    logic res_found_reg, res_cont_reg;
    logic [PolyW-1:0] res_idx_reg;
    logic found_reg, cont_reg;
    logic [PolyW-1:0] idx_reg;

    // submodule links
    logic             vs_we;
    logic [AddrW-1:0] vs_wr_addr, vs_rd_addr;
    vertex_t          vs_wr_data, vs_rd_data;
    logic             cs_we;
    logic [CountW-1:0] cs_rd_count;
    logic             mul_en;
    logic [MulW-1:0]  mul_a, mul_b;
    logic [ProdW-1:0] prod;
    logic             div_start;
    div_stat_t        div_stat;
    logic [QuoW-1:0]  quotient;

    // helpers
    logic              accept;
    logic [CountW-1:0] cnt_clamped;
    logic              last_edge;
    logic [VertW-1:0]  next_edge;
    logic              crossing;
    logic              last_step;
    logic [SumW-1:0]   dot;
    logic              near_start, past_end;
    logic [MagW:0]     ax_w, ax_f, ax_d;
    logic [ProdW:0]    sval;
    logic              hit;
    logic [NumW-1:0]   pp;

    function automatic logic [MagW:0] sdiff(input logic signed [CoordW-1:0] a,
                                            input logic signed [CoordW-1:0] b);
        logic [CoordW:0] t;
        logic [CoordW:0] m;
        t = {a[CoordW-1], a} - {b[CoordW-1], b};
        m = t[CoordW] ? (~t + 1'b1) : t;
        return {t[CoordW], m[MagW-1:0]};
    endfunction

    function automatic logic [DistW-1:0] sat_sum(input logic [SumW-1:0] v);
        return (|v[SumW-1:DistW]) ? '1 : v[DistW-1:0];
    endfunction

    plq_vertex_store u_vstore (
        .clk     (clk),
        .we      (vs_we),
        .wr_addr (vs_wr_addr),
        .wr_data (vs_wr_data),
        .rd_addr (vs_rd_addr),
        .rd_data (vs_rd_data)
    );

    plq_count_store u_cstore (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (cs_we),
        .wr_addr  (poly_slot),
        .wr_data  (vertex_total),
        .rd_addr  (poly_reg[PolyW-1:0]),
        .rd_count (cs_rd_count)
    );

    plq_mul_unit u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    plq_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (wacc_reg),
        .den      (ll_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign accept      = in_valid && in_ready;
    assign cnt_clamped = (cs_rd_count > CountW'(MaxVertices)) ? CountW'(MaxVertices)
                                                              : cs_rd_count;
    assign last_edge   = (CountW'(edge_reg) + 1'b1) == cnt_reg;
    assign next_edge   = last_edge ? '0 : edge_reg + 1'b1;
    // vb is the later vertex, va the earlier one
    assign crossing    = (vb_reg.z > ptz_reg) != (va_reg.z > ptz_reg);
    assign dot         = pos_reg - neg_reg;
    assign near_start  = (ll_reg == '0) || (pos_reg <= neg_reg);
    assign past_end    = dot >= ll_reg;

    always_comb
    begin
        case (step_reg[3:2])
            2'd0:
            begin
                ax_w = w_reg[0];
                ax_f = f_reg[0];
                ax_d = d_reg[0];
            end
            2'd1:
            begin
                ax_w = w_reg[1];
                ax_f = f_reg[1];
                ax_d = d_reg[1];
            end
            2'd2:
            begin
                ax_w = w_reg[2];
                ax_f = f_reg[2];
                ax_d = d_reg[2];
            end
            default:
            begin
                ax_w = '0;
                ax_f = '0;
                ax_d = '0;
            end
        endcase
    end

    // signed form of the crossing product, negative zero kept positive
    always_comb
    begin
        logic n;
        logic [ProdW:0] v;
        v = {1'b0, prod};
        if (!step_reg[0])
        begin
            n = (lx_reg[MagW] ^ dz_reg[MagW]) && (prod != '0);
        end
        else
        begin
            n = (ex_reg[MagW] ^ pz_reg[MagW]) && (prod != '0);
        end
        sval = n ? (~v + 1'b1) : v;
    end

    assign hit = !dz_reg[MagW] ? ($signed(s1_reg) < $signed(sval))
                               : ($signed(sval) < $signed(s1_reg));

    always_comb
    begin
        case ({step_reg[1], step_reg[0]})
            2'b00:   pp = NumW'(prod);
            2'b11:   pp = NumW'(prod) << (2 * MulW);
            default: pp = NumW'(prod) << MulW;
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            MODE_CONTAIN: last_step = step_reg == StepW'(1);
            MODE_DIST:    last_step = step_reg == StepW'(11);
            MODE_WIDE:    last_step = step_reg == StepW'(7);
            default:      last_step = 1'b1;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && op == OP_QUERY)
                begin
                    state_next = ST_CNT_RD;
                end
            end
            ST_CNT_RD:   state_next = (poly_reg == n_reg) ? ST_MUL : ST_CNT_GET;
            ST_CNT_GET:  state_next = (cnt_clamped == '0) ? ST_POLY_END : ST_LD_A;
            ST_LD_A:     state_next = ST_LD_B;
            ST_LD_B:     state_next = ST_LD_C;
            ST_LD_C:     state_next = ST_DIFF;
            ST_DIFF:
            begin
                state_next = (contain_phase_reg && !crossing) ? ST_EDGE_END : ST_MUL;
            end
            ST_MUL:      state_next = ST_ACC;
            ST_ACC:
            begin
                if (!last_step)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    case (mode_reg)
                        MODE_CONTAIN: state_next = ST_EDGE_END;
                        MODE_DIST:    state_next = ST_DECIDE;
                        MODE_WIDE:    state_next = ST_DIV_GO;
                        default:      state_next = ST_FINAL;
                    endcase
                end
            end
            ST_DECIDE:   state_next = (near_start || past_end) ? ST_EDGE_END : ST_MUL;
            ST_DIV_GO:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_EDGE_END;
                end
            end
            ST_EDGE_END:
            begin
                if (!last_edge)
                begin
                    state_next = ST_LD_A;
                end
                else if (contain_phase_reg)
                begin
                    state_next = inside_reg ? ST_OUT : ST_LD_A;
                end
                else
                begin
                    state_next = ST_POLY_END;
                end
            end
            ST_POLY_END: state_next = ST_CNT_RD;
            ST_FINAL:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready   = state_reg == ST_IDLE;
        vs_we      = accept && op == OP_WRITE;
        cs_we      = accept && op == OP_WRITE;
        vs_wr_addr = {poly_slot, vertex_slot};
        vs_wr_data = '{x: coord_x, y: coord_y, z: coord_z};
        vs_rd_addr = (state_reg == ST_LD_A) ? {poly_reg[PolyW-1:0], edge_reg}
                                            : {poly_reg[PolyW-1:0], next_edge};
        mul_en     = state_reg == ST_MUL;
        div_start  = state_reg == ST_DIV_GO;
        mul_a      = '0;
        mul_b      = '0;
        case (mode_reg)
            MODE_CONTAIN:
            begin
                mul_a = step_reg[0] ? MulW'(ex_reg[MagW-1:0]) : MulW'(lx_reg[MagW-1:0]);
                mul_b = step_reg[0] ? MulW'(pz_reg[MagW-1:0]) : MulW'(dz_reg[MagW-1:0]);
            end
            MODE_DIST:
            begin
                case (step_reg[1:0])
                    2'd0:
                    begin
                        mul_a = MulW'(ax_w[MagW-1:0]);
                        mul_b = MulW'(ax_w[MagW-1:0]);
                    end
                    2'd1:
                    begin
                        mul_a = MulW'(ax_f[MagW-1:0]);
                        mul_b = MulW'(ax_f[MagW-1:0]);
                    end
                    2'd2:
                    begin
                        mul_a = MulW'(ax_d[MagW-1:0]);
                        mul_b = MulW'(ax_d[MagW-1:0]);
                    end
                    default:
                    begin
                        mul_a = MulW'(ax_w[MagW-1:0]);
                        mul_b = MulW'(ax_d[MagW-1:0]);
                    end
                endcase
            end
            MODE_WIDE:
            begin
                // ww*ll partials first, then dot*dot partials
                if (!step_reg[2])
                begin
                    mul_a = step_reg[1] ? ww_reg[SumW-1:MulW] : ww_reg[MulW-1:0];
                    mul_b = step_reg[0] ? ll_reg[SumW-1:MulW] : ll_reg[MulW-1:0];
                end
                else
                begin
                    mul_a = step_reg[1] ? dot_reg[SumW-1:MulW] : dot_reg[MulW-1:0];
                    mul_b = step_reg[0] ? dot_reg[SumW-1:MulW] : dot_reg[MulW-1:0];
                end
            end
            default:
            begin
                mul_a = MulW'(radius_reg);
                mul_b = MulW'(radius_reg);
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            mode_reg          <= MODE_CONTAIN;
            pcount_reg        <= '0;
            radius_reg        <= RadiusW'(32768);
            n_reg             <= '0;
            poly_reg          <= '0;
            edge_reg          <= '0;
            cnt_reg           <= '0;
            step_reg          <= '0;
            contain_phase_reg <= 1'b0;
            inside_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POLYGON_COUNT: pcount_reg <= cfg_data[PolyCountW-1:0];
                    CFG_AGENT_RADIUS:  radius_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && op == OP_QUERY)
                    begin
                        poly_reg <= '0;
                        n_reg    <= (pcount_reg > PolyCountW'(MaxPolygons))
                                    ? PolyCountW'(MaxPolygons) : pcount_reg;
                    end
                end
                ST_CNT_RD:
                begin
                    mode_reg <= MODE_RADIUS;
                    step_reg <= '0;
                end
                ST_CNT_GET:
                begin
                    cnt_reg           <= cnt_clamped;
                    edge_reg          <= '0;
                    inside_reg        <= 1'b0;
                    contain_phase_reg <= cnt_clamped >= CountW'(3);
                end
                ST_DIFF:
                begin
                    step_reg <= '0;
                    mode_reg <= contain_phase_reg ? MODE_CONTAIN : MODE_DIST;
                end
                ST_ACC:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (mode_reg == MODE_CONTAIN && step_reg[0] && hit)
                    begin
                        inside_reg <= !inside_reg;
                    end
                end
                ST_DECIDE:
                begin
                    step_reg <= '0;
                    mode_reg <= MODE_WIDE;
                end
                ST_EDGE_END:
                begin
                    if (!last_edge)
                    begin
                        edge_reg <= edge_reg + 1'b1;
                    end
                    else
                    begin
                        edge_reg <= '0;
                        if (contain_phase_reg && !inside_reg)
                        begin
                            contain_phase_reg <= 1'b0;
                        end
                    end
                end
                ST_POLY_END: poly_reg <= poly_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && op == OP_QUERY)
                begin
                    ptx_reg      <= coord_x;
                    pty_reg      <= coord_y;
                    ptz_reg      <= coord_z;
                    best_reg     <= '1;
                    best_idx_reg <= '0;
                end
            end
            ST_CNT_GET: dist_reg <= '1;
            ST_LD_B:    va_reg <= vs_rd_data;
            ST_LD_C:    vb_reg <= vs_rd_data;
            ST_DIFF:
            begin
                d_reg[0] <= sdiff(vb_reg.x, va_reg.x);
                d_reg[1] <= sdiff(vb_reg.y, va_reg.y);
                d_reg[2] <= sdiff(vb_reg.z, va_reg.z);
                w_reg[0] <= sdiff(ptx_reg, va_reg.x);
                w_reg[1] <= sdiff(pty_reg, va_reg.y);
                w_reg[2] <= sdiff(ptz_reg, va_reg.z);
                f_reg[0] <= sdiff(ptx_reg, vb_reg.x);
                f_reg[1] <= sdiff(pty_reg, vb_reg.y);
                f_reg[2] <= sdiff(ptz_reg, vb_reg.z);
                lx_reg   <= sdiff(ptx_reg, vb_reg.x);
                ex_reg   <= sdiff(va_reg.x, vb_reg.x);
                pz_reg   <= sdiff(ptz_reg, vb_reg.z);
                dz_reg   <= sdiff(va_reg.z, vb_reg.z);
                ww_reg   <= '0;
                ff_reg   <= '0;
                ll_reg   <= '0;
                pos_reg  <= '0;
                neg_reg  <= '0;
            end
            ST_ACC:
            begin
                case (mode_reg)
                    MODE_CONTAIN:
                    begin
                        if (!step_reg[0])
                        begin
                            s1_reg <= sval;
                        end
                    end
                    MODE_DIST:
                    begin
                        case (step_reg[1:0])
                            2'd0: ww_reg <= ww_reg + prod;
                            2'd1: ff_reg <= ff_reg + prod;
                            2'd2: ll_reg <= ll_reg + prod;
                            default:
                            begin
                                if (ax_w[MagW] != ax_d[MagW])
                                begin
                                    neg_reg <= neg_reg + prod;
                                end
                                else
                                begin
                                    pos_reg <= pos_reg + prod;
                                end
                            end
                        endcase
                    end
                    MODE_WIDE:
                    begin
                        wacc_reg <= step_reg[2] ? wacc_reg - pp : wacc_reg + pp;
                    end
                    default: r2_reg <= prod[R2W-1:0];
                endcase
            end
            ST_DECIDE:
            begin
                // degenerate edge or point behind the start: distance to the start
                if (near_start)
                begin
                    dk_reg <= sat_sum(ww_reg);
                end
                else if (past_end)
                begin
                    dk_reg <= sat_sum(ff_reg);
                end
                dot_reg  <= dot;
                wacc_reg <= '0;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    dk_reg <= (|quotient[QuoW-1:DistW]) ? '1 : quotient[DistW-1:0];
                end
            end
            ST_EDGE_END:
            begin
                if (!contain_phase_reg && dk_reg < dist_reg)
                begin
                    dist_reg <= dk_reg;
                end
                if (contain_phase_reg && last_edge && inside_reg)
                begin
                    res_found_reg <= 1'b1;
                    res_idx_reg   <= poly_reg[PolyW-1:0];
                    res_cont_reg  <= 1'b1;
                end
            end
            ST_POLY_END:
            begin
                if (dist_reg < best_reg)
                begin
                    best_reg     <= dist_reg;
                    best_idx_reg <= poly_reg[PolyW-1:0];
                end
            end
            ST_FINAL:
            begin
                res_found_reg <= best_reg < DistW'(r2_reg);
                res_idx_reg   <= (best_reg < DistW'(r2_reg)) ? best_idx_reg : '0;
                res_cont_reg  <= 1'b0;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    found_reg <= res_found_reg;
                    idx_reg   <= res_idx_reg;
                    cont_reg  <= res_cont_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = idx_reg;
    assign contained   = cont_reg;

`ifndef NO_ASSERTIONS
    a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_GO |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LD_A |-> (CountW'(edge_reg) < cnt_reg)
                                 && (cnt_reg <= CountW'(MaxVertices)))
        else $error("edge index beyond polygon vertex count");

    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_index == '0 && !contained)
        else $error("result without a match carries an index or containment");
`endif

endmodule

@@ rtl/plq_vertex_store.sv @@
// plq_vertex_store: polygon vertex memory, one write and one registered read a cycle
// depends on plq_pkg

module plq_vertex_store
    import plq_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] wr_addr,
    input  vertex_t          wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output vertex_t          rd_data
);

    vertex_t mem [MaxPolygons*MaxVertices];
    vertex_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/plq_count_store.sv @@
// plq_count_store: per-polygon vertex counts with valid bits, unwritten reads zero
// depends on plq_pkg

module plq_count_store
    import plq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [PolyW-1:0]  wr_addr,
    input  logic [CountW-1:0] wr_data,
    input  logic [PolyW-1:0]  rd_addr,
    output logic [CountW-1:0] rd_count
);

    logic [CountW-1:0] mem [MaxPolygons];
    logic [MaxPolygons-1:0] valid_reg;
    logic [CountW-1:0] rd_data_reg;
    logic rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_count = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/plq_mul_unit.sv @@
// plq_mul_unit: the shared 33x33 unsigned multiplier with a registered product
// depends on plq_pkg

module plq_mul_unit
    import plq_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [MulW-1:0]  a,
    input  logic [MulW-1:0]  b,
    output logic [ProdW-1:0] prod
);

    logic [ProdW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= ProdW'(a) * ProdW'(b);
        end
    end

    assign prod = prod_reg;

endmodule

@@ rtl/plq_divider.sv @@
// plq_divider: restoring divider, one quotient bit a cycle, for the edge projection
// depends on plq_pkg; numerator must give a quotient below 2^QuoW

module plq_divider
    import plq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NumW-1:0] num,
    input  logic [SumW-1:0] den,
    output div_stat_t       stat,
    output logic [QuoW-1:0] quotient
);

    localparam int CntW = $clog2(QuoW + 1);

    logic [SumW-1:0] rem_reg;
    logic [QuoW-1:0] low_reg;
    logic [QuoW-1:0] quo_reg;
    logic [CntW-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [SumW:0] trial;
    logic [SumW:0] diff;
    logic take;

    assign trial = {rem_reg, low_reg[QuoW-1]};
    assign diff  = trial - {1'b0, den};
    assign take  = trial >= {1'b0, den};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= SumW'(num[NumW-1:QuoW]);
            low_reg <= num[QuoW-1:0];
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[SumW-1:0] : trial[SumW-1:0];
            low_reg <= {low_reg[QuoW-2:0], 1'b0};
            quo_reg <= {quo_reg[QuoW-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(QuoW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
